// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// ===== hdl/dbmrt_pkg.sv =====
`default_nettype none

package dbmrt_pkg;

  localparam int DescWords  = 4;
  localparam int WordBits   = 64;
  localparam int DescBits   = DescWords * WordBits;
  localparam int DistW      = 9;
  localparam int LvlW       = 3;
  localparam int IdxW       = 12;
  localparam int RadW       = 15;
  localparam int OffW       = 16;

  localparam int QDepth     = 8;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = QPtrW + 1;

  localparam logic [DistW-1:0] MaxHammingReset = DistW'(100);

  localparam logic KindHeader    = 1'b0;
  localparam logic KindCandidate = 1'b1;

  // register byte addresses (index 4*i)
  localparam logic [2:0] AddrMaxHamming = 3'd0;

  // Classified header or candidate passed from the front end to the tracker.
  typedef struct packed {
    logic             kind;
    logic             pass;   // candidate, in range and not used
    logic [DistW-1:0] ham;
    logic [LvlW-1:0]  lvl;
    logic [IdxW-1:0]  idx;
    logic             last;
  } item_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dbmrt_front.sv =====
`default_nettype none

module dbmrt_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic                              kind,
  input  wire logic [dbmrt_pkg::DescBits-1:0]    desc,
  input  wire logic [dbmrt_pkg::RadW-1:0]        radius,
  input  wire logic [dbmrt_pkg::OffW-1:0]        offset_x,
  input  wire logic [dbmrt_pkg::OffW-1:0]        offset_y,
  input  wire logic [dbmrt_pkg::LvlW-1:0]        level,
  input  wire logic [dbmrt_pkg::IdxW-1:0]        feature_index,
  input  wire logic                              already_used,
  input  wire logic                              last,
  input  wire logic [dbmrt_pkg::QCntW-1:0]       q_count,
  output logic                                   push,
  output dbmrt_pkg::item_t                       push_item
);

  localparam int NBytes = dbmrt_pkg::DescBits / 8;
  localparam int BytesPerWord = dbmrt_pkg::WordBits / 8;
  localparam int WCntW = $clog2(dbmrt_pkg::WordBits + 1);
  localparam int OccW = dbmrt_pkg::QCntW + 1;

  typedef struct packed {
    logic                      kind;
    logic                      used;
    logic                      last;
    logic [dbmrt_pkg::LvlW-1:0] lvl;
    logic [dbmrt_pkg::IdxW-1:0] idx;
  } ctl_t;

  logic                               accept;
  logic [OccW-1:0]                    occ;

  logic [dbmrt_pkg::DescBits-1:0]     query_r;
  logic [dbmrt_pkg::RadW-1:0]         radius_r;

  logic                               a_vld_r, b_vld_r, c_vld_r, d_vld_r;
  ctl_t                               a_ctl_r, b_ctl_r, c_ctl_r;
  logic [dbmrt_pkg::DescBits-1:0]     a_xor_r;
  logic [dbmrt_pkg::OffW-1:0]         a_ax_r, a_ay_r;
  logic [dbmrt_pkg::RadW-1:0]         a_rad_r;
  logic [NBytes-1:0][3:0]             b_bytes_r;
  logic [31:0]                        b_x2_r, b_y2_r;
  logic [29:0]                        b_r2_r;
  logic [dbmrt_pkg::DescWords-1:0][WCntW-1:0] c_words_r;
  logic                               c_inr_r;
  dbmrt_pkg::item_t                   d_item_r;

  logic [dbmrt_pkg::OffW-1:0]         ax, ay;
  logic [NBytes-1:0][3:0]             bytes_nxt;
  logic [dbmrt_pkg::DescWords-1:0][WCntW-1:0] words_nxt;
  logic [32:0]                        d2;
  logic [dbmrt_pkg::DistW-1:0]        ham_nxt;

  // credit: every item in flight has a queue slot reserved
  assign occ = OccW'(q_count) + OccW'(a_vld_r) + OccW'(b_vld_r)
             + OccW'(c_vld_r) + OccW'(d_vld_r);
  assign in_tready = (occ < OccW'(dbmrt_pkg::QDepth));
  assign accept = in_tvalid && in_tready;

  assign ax = offset_x[dbmrt_pkg::OffW-1] ? (~offset_x + dbmrt_pkg::OffW'(1)) : offset_x;
  assign ay = offset_y[dbmrt_pkg::OffW-1] ? (~offset_y + dbmrt_pkg::OffW'(1)) : offset_y;

  always_comb begin
    for (int i = 0; i < NBytes; i++) begin
      bytes_nxt[i] = dbmrt_pkg::pop8(a_xor_r[i*8 +: 8]);
    end
  end

  always_comb begin
    for (int w = 0; w < dbmrt_pkg::DescWords; w++) begin
      words_nxt[w] = '0;
      for (int j = 0; j < BytesPerWord; j++) begin
        words_nxt[w] = words_nxt[w] + WCntW'(b_bytes_r[w*BytesPerWord + j]);
      end
    end
  end

  assign d2 = 33'(b_x2_r) + 33'(b_y2_r);

  always_comb begin
    ham_nxt = '0;
    for (int w = 0; w < dbmrt_pkg::DescWords; w++) begin
      ham_nxt = ham_nxt + dbmrt_pkg::DistW'(c_words_r[w]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r  <= '0;
      radius_r <= '0;
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
      d_vld_r  <= 1'b0;
    end else begin
      if (accept && kind == dbmrt_pkg::KindHeader) begin
        query_r  <= desc;
        radius_r <= radius;
      end
      a_vld_r <= accept;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  // datapath: stage A xor/abs, B byte counts/squares, C word sums/range, D distance
  always_ff @(posedge clk) begin
    a_ctl_r   <= '{kind: kind, used: already_used, last: last,
                   lvl: level, idx: feature_index};
    a_xor_r   <= desc ^ query_r;
    a_ax_r    <= ax;
    a_ay_r    <= ay;
    a_rad_r   <= radius_r;

    b_ctl_r   <= a_ctl_r;
    b_bytes_r <= bytes_nxt;
    b_x2_r    <= 32'(a_ax_r) * 32'(a_ax_r);
    b_y2_r    <= 32'(a_ay_r) * 32'(a_ay_r);
    b_r2_r    <= 30'(a_rad_r) * 30'(a_rad_r);

    c_ctl_r   <= b_ctl_r;
    c_words_r <= words_nxt;
    c_inr_r   <= (d2 <= 33'(b_r2_r));

    d_item_r.kind <= c_ctl_r.kind;
    d_item_r.pass <= (c_ctl_r.kind == dbmrt_pkg::KindCandidate) && !c_ctl_r.used
                     && c_inr_r;
    d_item_r.ham  <= ham_nxt;
    d_item_r.lvl  <= c_ctl_r.lvl;
    d_item_r.idx  <= c_ctl_r.idx;
    d_item_r.last <= c_ctl_r.last;
  end

  assign push      = d_vld_r;
  assign push_item = d_item_r;

endmodule

`default_nettype wire

// ===== hdl/dbmrt_fifo.sv =====
`default_nettype none

module dbmrt_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire dbmrt_pkg::item_t              push_item,
  input  wire logic                          pop,
  output logic                               head_valid,
  output dbmrt_pkg::item_t                   head_item,
  output logic [dbmrt_pkg::QCntW-1:0]        count
);

  dbmrt_pkg::item_t                  mem_r [dbmrt_pkg::QDepth];
  logic [dbmrt_pkg::QPtrW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [dbmrt_pkg::QCntW-1:0]       count_r;

  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign count      = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + dbmrt_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + dbmrt_pkg::QPtrW'(1);
      end
      count_r <= count_r + dbmrt_pkg::QCntW'(push) - dbmrt_pkg::QCntW'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dbmrt_back.sv =====
`default_nettype none

module dbmrt_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          head_valid,
  input  wire dbmrt_pkg::item_t              head_item,
  output logic                               pop,
  input  wire logic [dbmrt_pkg::DistW-1:0]   max_hamming,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic [dbmrt_pkg::IdxW-1:0]         out_index,
  output logic [dbmrt_pkg::DistW-1:0]        out_dist
);

  localparam int ProdW = dbmrt_pkg::DistW + 4;

  logic                         bv_r, sv_r;
  logic [dbmrt_pkg::DistW-1:0]  bd_r, sd_r;
  logic [dbmrt_pkg::LvlW-1:0]   bl_r, sl_r;
  logic [dbmrt_pkg::IdxW-1:0]   bi_r;

  logic                         bv_nxt, sv_nxt;
  logic [dbmrt_pkg::DistW-1:0]  bd_nxt, sd_nxt;
  logic [dbmrt_pkg::LvlW-1:0]   bl_nxt, sl_nxt;
  logic [dbmrt_pkg::IdxW-1:0]   bi_nxt;

  logic                         out_vld_r, found_r;
  logic [dbmrt_pkg::IdxW-1:0]   index_r;
  logic [dbmrt_pkg::DistW-1:0]  dist_r;

  logic                         ok, ambiguous;
  logic [ProdW-1:0]             best10, second9;

  // results wait in the output register; non-last items drain regardless
  assign pop = head_valid && (!head_item.last || !out_vld_r || out_ready);

  always_comb begin
    bv_nxt = bv_r;
    bd_nxt = bd_r;
    bl_nxt = bl_r;
    bi_nxt = bi_r;
    sv_nxt = sv_r;
    sd_nxt = sd_r;
    sl_nxt = sl_r;
    if (head_item.kind == dbmrt_pkg::KindHeader) begin
      bv_nxt = 1'b0;
      bd_nxt = '0;
      bl_nxt = '0;
      bi_nxt = '0;
      sv_nxt = 1'b0;
      sd_nxt = '0;
      sl_nxt = '0;
    end else if (head_item.pass && head_item.ham <= max_hamming) begin
      if (!bv_r || head_item.ham < bd_r) begin
        // demote best to second
        sv_nxt = bv_r;
        sd_nxt = bd_r;
        sl_nxt = bl_r;
        bv_nxt = 1'b1;
        bd_nxt = head_item.ham;
        bl_nxt = head_item.lvl;
        bi_nxt = head_item.idx;
      end else if (!sv_r || head_item.ham < sd_r) begin
        sv_nxt = 1'b1;
        sd_nxt = head_item.ham;
        sl_nxt = head_item.lvl;
      end
    end
  end

  // ratio test 10*best >= 9*second as shift-adds
  assign best10  = (ProdW'(bd_nxt) << 3) + (ProdW'(bd_nxt) << 1);
  assign second9 = (ProdW'(sd_nxt) << 3) + ProdW'(sd_nxt);
  assign ambiguous = sv_nxt && (bl_nxt == sl_nxt) && (best10 >= second9);
  assign ok = bv_nxt && (bd_nxt <= max_hamming) && !ambiguous;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r      <= 1'b0;
      bd_r      <= '0;
      bl_r      <= '0;
      bi_r      <= '0;
      sv_r      <= 1'b0;
      sd_r      <= '0;
      sl_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        if (head_item.last) begin
          bv_r <= 1'b0;
          bd_r <= '0;
          bl_r <= '0;
          bi_r <= '0;
          sv_r <= 1'b0;
          sd_r <= '0;
          sl_r <= '0;
        end else begin
          bv_r <= bv_nxt;
          bd_r <= bd_nxt;
          bl_r <= bl_nxt;
          bi_r <= bi_nxt;
          sv_r <= sv_nxt;
          sd_r <= sd_nxt;
          sl_r <= sl_nxt;
        end
      end
      if (pop && head_item.last) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      found_r <= ok;
      index_r <= ok ? bi_nxt : '0;
      dist_r  <= ok ? bd_nxt : '0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_found = found_r;
  assign out_index = index_r;
  assign out_dist  = dist_r;

endmodule

`default_nettype wire

// ===== hdl/descriptor_best_match_ratio_test.sv =====
// Hamming descriptor best match with ratio test.
// Input stream: in_tuser selects a header (0) or a candidate (1); in_tlast closes a
// query. A header loads the query descriptor and search radius and clears the
// best/second trackers. Candidates that are unused, inside the radius and within
// max_hamming update the trackers. Every item with in_tlast produces one result
// transaction on the out_ channel; other items produce none.
// Throughput: one item per cycle, sustained unless out_tready stalls results
// long enough to fill the queue, which drops in_tready. An item passes the
// four-stage distance/range pipeline, the queue and the output register on
// its way to out_tvalid. The only loop is the tracker update in the back end.
// max_hamming is written over the APB port at address 0 (reset value 100);
// write it only while the block is idle.
// Reset (rst_n low, synchronous) clears the query, radius, trackers and queue.
// When out_tready is low the result holds in the output register; the queue
// keeps filling and in_tready drops once all queue slots are spoken for.
`default_nettype none

`include "assert_macros.svh"

module descriptor_best_match_ratio_test (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // desc_word0..3 [255:0], search_radius [270:256], offset_x [286:271],
  // offset_y [302:287], level [305:303], feature_index [317:306],
  // already_used [318], zero [319]
  input  wire logic [319:0] in_tdata,
  // kind [0]
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // found [0], match_index [12:1], match_distance [21:13], zero [23:22]
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [dbmrt_pkg::DistW-1:0]  max_hamming_r;
  logic                         cfg_wr;

  logic                         push, pop, head_valid;
  dbmrt_pkg::item_t             push_item, head_item;
  logic [dbmrt_pkg::QCntW-1:0]  q_count;

  logic                         found;
  logic [dbmrt_pkg::IdxW-1:0]   match_index;
  logic [dbmrt_pkg::DistW-1:0]  match_distance;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_hamming_r <= dbmrt_pkg::MaxHammingReset;
    end else if (cfg_wr && cfg_paddr[2] == dbmrt_pkg::AddrMaxHamming[2]) begin
      max_hamming_r <= cfg_pwdata[dbmrt_pkg::DistW-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == dbmrt_pkg::AddrMaxHamming[2])
                    ? 32'(max_hamming_r) : 32'd0;

  dbmrt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .kind          (in_tuser),
    .desc          (in_tdata[255:0]),
    .radius        (in_tdata[270:256]),
    .offset_x      (in_tdata[286:271]),
    .offset_y      (in_tdata[302:287]),
    .level         (in_tdata[305:303]),
    .feature_index (in_tdata[317:306]),
    .already_used  (in_tdata[318]),
    .last          (in_tlast),
    .q_count       (q_count),
    .push          (push),
    .push_item     (push_item)
  );

  dbmrt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  dbmrt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .max_hamming (max_hamming_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_found   (found),
    .out_index   (match_index),
    .out_dist    (match_distance)
  );

  assign out_tdata = {2'b00, match_distance, match_index, found};

  `ASSERT_NEVER(a_q_overflow, clk, rst_n, push && !pop && (q_count == dbmrt_pkg::QCntW'(dbmrt_pkg::QDepth)), "queue overflow")
  `ASSERT_NEVER(a_q_underflow, clk, rst_n, pop && !head_valid, "pop from empty queue")
  `ASSERT_CLK(a_result_src, clk, rst_n, (out_tvalid && !$past(out_tvalid)) |-> $past(pop && head_item.last), "result without closing item")
  `ASSERT_CLK(a_refused_zero, clk, rst_n, (out_tvalid && !found) |-> (match_index == '0 && match_distance == '0), "refused result carries data")

endmodule

`default_nettype wire
